// ----- rtl/core/rebq_pkg.sv -----
// Shared constants and the quadrature transition table for the rotary encoder
// and push-switch qualifier. No dependencies; used by the top level and the checker.

package rebq_pkg;

  localparam int unsigned RUN_W   = 8;
  localparam int unsigned SUM_W   = 8;
  localparam int unsigned THR_W   = 8;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned ADDR_W  = 3;

  localparam logic [RUN_W-1:0] RUN_MAX      = 8'hFF;
  localparam logic [THR_W-1:0] THRESH_RESET = 8'd10;
  localparam logic [1:0]       HIST_RESET   = 2'b11;
  localparam logic [SUM_W-1:0] SUM_POS      = 8'h02;
  localparam logic [SUM_W-1:0] SUM_NEG      = 8'hFE;

  // Register indexes, taken from paddr[2].
  localparam logic REG_THRESHOLD = 1'b0;

  localparam logic signed [1:0] STEP_NONE = 2'sb00;
  localparam logic signed [1:0] STEP_POS  = 2'sb01;
  localparam logic signed [1:0] STEP_NEG  = 2'sb11;

  // Increment per transition {old_a, old_b, new_a, new_b}. Invalid double
  // transitions add 14, which leaves the parity of the sum unchanged.
  function automatic logic [SUM_W-1:0] step_lut(input logic [3:0] idx);
    logic [SUM_W-1:0] v;
    unique case (idx)
      4'd0, 4'd5, 4'd10, 4'd15:       v = 8'h00;
      4'd1, 4'd7, 4'd8, 4'd14:        v = 8'hFF;
      4'd2, 4'd4, 4'd11, 4'd13:       v = 8'h01;
      4'd3, 4'd6, 4'd9, 4'd12:        v = 8'd14;
      default:                        v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/core/rebq_if.sv -----
// Valid/ready channel interfaces for the encoder qualifier's sample and
// result words. Depends on nothing but the language.

interface rebq_in_if;
  logic valid;
  logic ready;
  logic switch_level;
  logic phase_a;
  logic phase_b;

  modport source(output valid, output switch_level, output phase_a, output phase_b,
                 input ready);
  modport sink(input valid, input switch_level, input phase_a, input phase_b,
               output ready);
endinterface

interface rebq_out_if;
  logic              valid;
  logic              ready;
  logic              switch_event;
  logic              switch_pressed;
  logic              turn_event;
  logic              turn_clockwise;
  logic signed [1:0] step;

  modport source(output valid, output switch_event, output switch_pressed,
                 output turn_event, output turn_clockwise, output step, input ready);
  modport sink(input valid, input switch_event, input switch_pressed,
               input turn_event, input turn_clockwise, input step, output ready);
endinterface

// ----- rtl/core/rotary_encoder_and_button_qualifier_unit.sv -----
// Rotary encoder and push-switch qualifier, top level.
// Depends on rebq_pkg and the channel interfaces in rebq_if.sv.
//
// Usage:
//   in_if carries one poll sample per word: the switch pin (0 pressed) and
//   the encoder lines A and B. out_if returns exactly one result word per
//   sample: debounced switch event and state, detent event, last direction
//   and a signed step of +1, -1 or 0.
//   The APB port holds one register, the debounce threshold at address 0;
//   a run of samples must exceed it before a switch change is taken.
//   The result word is registered and valid in the cycle after the sample is
//   accepted. Throughput is one word per cycle while out_if is ready; the state update
//   is a single pass of small logic that feeds the result register.
//   When the receiver stalls, the result register holds its word and in_if
//   stays ready only if that word leaves in the same cycle.
//   A synchronous low rst_n clears the run counters, sets the switch to
//   released, the phase history to both lines high, the sum to zero, and
//   the threshold to 10; no result word is pending after reset.

module rotary_encoder_and_button_qualifier_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  rebq_in_if.sink                      in_if,
  rebq_out_if.source                   out_if,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rebq_pkg::ADDR_W-1:0]  paddr,
  input  logic [rebq_pkg::DATA_W-1:0]  pwdata,
  output logic [rebq_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);

  logic [rebq_pkg::THR_W-1:0] thresh_r;
  logic [rebq_pkg::RUN_W-1:0] press_run_r, press_run_nxt;
  logic [rebq_pkg::RUN_W-1:0] release_run_r, release_run_nxt;
  logic                       level_r, level_nxt;   // debounced, 1 released
  logic [1:0]                 hist_r, hist_nxt;
  logic [rebq_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic                       dir_r, dir_nxt;

  logic                       out_valid_r;
  logic                       sw_event_r, sw_event_nxt;
  logic                       turn_event_r, turn_event_nxt;
  logic signed [1:0]          step_r, step_nxt;

  logic                       accept;
  logic [rebq_pkg::RUN_W-1:0] p1, r1, r2, r3, p3;
  logic                       lvl2;
  logic                       press_hit, release_hit;
  logic [rebq_pkg::SUM_W-1:0] sum_add;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == rebq_pkg::REG_THRESHOLD)
                  ? {{(rebq_pkg::DATA_W-rebq_pkg::THR_W){1'b0}}, thresh_r}
                  : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= rebq_pkg::THRESH_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == rebq_pkg::REG_THRESHOLD) begin
      thresh_r <= pwdata[rebq_pkg::THR_W-1:0];
    end
  end

  assign in_if.ready = !out_valid_r || out_if.ready;
  assign accept      = in_if.valid && in_if.ready;

  // Switch debounce, in the same order as the checks: press side first,
  // so a lowered threshold can take a press and a release in one sample.
  always_comb begin
    p1 = press_run_r;
    r1 = release_run_r;
    if (!in_if.switch_level) begin
      p1 = (press_run_r == rebq_pkg::RUN_MAX) ? press_run_r : press_run_r + 8'd1;
      r1 = '0;
    end
    press_hit = (p1 > thresh_r) && level_r;
    lvl2      = press_hit ? 1'b0 : level_r;
    r2        = press_hit ? '0 : r1;

    r3 = r2;
    p3 = p1;
    if (in_if.switch_level) begin
      r3 = (r2 == rebq_pkg::RUN_MAX) ? r2 : r2 + 8'd1;
      p3 = '0;
    end
    release_hit     = (r3 > thresh_r) && !lvl2;
    level_nxt       = release_hit ? 1'b1 : lvl2;
    press_run_nxt   = release_hit ? '0 : p3;
    release_run_nxt = r3;
    sw_event_nxt    = press_hit || release_hit;
  end

  // Quadrature decode. Only the last A/B pair of the history is needed.
  always_comb begin
    hist_nxt       = {in_if.phase_a, in_if.phase_b};
    sum_add        = sum_r + rebq_pkg::step_lut({hist_r, in_if.phase_a, in_if.phase_b});
    sum_nxt        = sum_add;
    dir_nxt        = dir_r;
    turn_event_nxt = 1'b0;
    step_nxt       = rebq_pkg::STEP_NONE;
    if (!sum_add[0]) begin
      if (sum_add == rebq_pkg::SUM_POS) begin
        dir_nxt        = 1'b1;
        turn_event_nxt = 1'b1;
        step_nxt       = rebq_pkg::STEP_POS;
      end else if (sum_add == rebq_pkg::SUM_NEG) begin
        dir_nxt        = 1'b0;
        turn_event_nxt = 1'b1;
        step_nxt       = rebq_pkg::STEP_NEG;
      end
      sum_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_run_r   <= '0;
      release_run_r <= '0;
      level_r       <= 1'b1;
      hist_r        <= rebq_pkg::HIST_RESET;
      sum_r         <= '0;
      dir_r         <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (accept) begin
        press_run_r   <= press_run_nxt;
        release_run_r <= release_run_nxt;
        level_r       <= level_nxt;
        hist_r        <= hist_nxt;
        sum_r         <= sum_nxt;
        dir_r         <= dir_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r   <= 1'b0;
      end
    end
  end

  // Result payload; the direction and switch state come from the state
  // registers, which change only together with this word.
  always_ff @(posedge clk) begin
    if (accept) begin
      sw_event_r   <= sw_event_nxt;
      turn_event_r <= turn_event_nxt;
      step_r       <= step_nxt;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.switch_event   = sw_event_r;
  assign out_if.switch_pressed = !level_r;
  assign out_if.turn_event     = turn_event_r;
  assign out_if.turn_clockwise = dir_r;
  assign out_if.step           = step_r;

endmodule

// ----- rtl/core/rebq_checker.sv -----
// Port-level checks for the encoder qualifier, bound to the top level.
// Depends on rebq_pkg and rotary_encoder_and_button_qualifier_unit.

module rebq_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_turn_event,
  input logic              out_turn_clockwise,
  input logic signed [1:0] out_step
);

  // A result word that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // Every accepted sample produces a word in the next cycle.
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted sample gave no result word");

  // The step is nonzero exactly on a detent event.
  a_step_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_turn_event == (out_step != rebq_pkg::STEP_NONE)))
    else $error("step and turn event disagree");

  // A detent step agrees with the reported direction.
  a_step_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_turn_event |-> (out_turn_clockwise == (out_step == rebq_pkg::STEP_POS)))
    else $error("step sign and direction disagree");

  // Reset leaves no word pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word pending after reset");

endmodule

bind rotary_encoder_and_button_qualifier_unit rebq_checker u_rebq_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_if.valid),
  .in_ready           (in_if.ready),
  .out_valid          (out_if.valid),
  .out_ready          (out_if.ready),
  .out_turn_event     (out_if.turn_event),
  .out_turn_clockwise (out_if.turn_clockwise),
  .out_step           (out_if.step)
);
